/* hw/rtl/oce_pkg.sv */
package oce_pkg;

    localparam int VAL_W   = 36;
    localparam int MAG_W   = 32;
    localparam int DIGIT_W = 4;
    localparam int Q_SHIFT = 30;

    localparam int DRAG_W   = 13;
    localparam int ZOOM_W   = 18;
    localparam int TARGET_W = 24;
    localparam int RAD_W    = 17;
    localparam int CFG_W    = 14;
    localparam int KIND_W   = 2;
    localparam int IN_W     = ((2 * DRAG_W + ZOOM_W + 3 * TARGET_W + 7) / 8) * 8;

    localparam int POLAR_EPS  = 10;
    localparam int RADIUS_MIN = 256;
    localparam int RADIUS_MAX = 128000;
    localparam int RADIUS_RST = 12800;
    localparam int WIDTH_RST  = 800;
    localparam int HEIGHT_RST = 600;

    localparam logic signed [VAL_W-1:0] SIN_COEF [6] = '{
        36'sd1686629713, -36'sd693598668, 36'sd85569306,
        -36'sd5026995, 36'sd172272, -36'sd3864
    };

    typedef enum logic [KIND_W-1:0] {
        KIND_ROTATE = 2'd0,
        KIND_ZOOM   = 2'd1,
        KIND_SET    = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

/* hw/rtl/oce_qmul.sv */
module oce_qmul
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [oce_pkg::VAL_W-1:0]   a,
    input  logic signed [oce_pkg::VAL_W-1:0]   b,
    output logic signed [oce_pkg::VAL_W-1:0]   q,
    output logic                               done
);
    import oce_pkg::*;

    localparam int STEPS = MAG_W / DIGIT_W;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int PROD_W = 2 * MAG_W;

    logic [MAG_W-1:0]   ma_reg, ma_next;
    logic [MAG_W-1:0]   mb_reg, mb_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [VAL_W-1:0] a_abs, b_abs, mag_ext;
    logic [MAG_W+DIGIT_W-1:0] part;

    assign a_abs = a[VAL_W-1] ? -a : a;
    assign b_abs = b[VAL_W-1] ? -b : b;
    assign part = ma_reg * mb_reg[MAG_W-1 -: DIGIT_W];
    assign mag_ext = VAL_W'(acc_reg[PROD_W-1:Q_SHIFT]);
    assign q = neg_reg ? -mag_ext : mag_ext;
    assign done = done_reg;

    always_comb
    begin
        ma_next = ma_reg;
        mb_next = mb_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            ma_next = a_abs[MAG_W-1:0];
            mb_next = b_abs[MAG_W-1:0];
            acc_next = '0;
            neg_next = a[VAL_W-1] ^ b[VAL_W-1];
            cnt_next = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << DIGIT_W) + PROD_W'(part);
            mb_next = mb_reg << DIGIT_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
    end

endmodule

/* hw/rtl/orbit_camera_eye_update.sv */
// Orbit camera unit: each request on the input stream (rotate by a drag, zoom, or set
// the look-at point, chosen by tuser) updates the camera and yields one result with the
// eye position and the new azimuth, polar angle and radius. One request is worked at a
// time. A rotate request first runs two restoring dividers side by side, which yield
// 13+ANGLE_BITS quotient bits each; every request then takes 32 products on one shared
// multiplier that consumes a 4-bit digit per cycle. A finished result waits in the output
// register while the next request is accepted. Viewport sizes are written over APB at byte
// addresses 0 and 4.
module orbit_camera_eye_update
#(
    parameter int ANGLE_BITS = 16,
    parameter int POS_BITS   = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // drag_x, drag_y, zoom_amount, target_x, target_y, target_z
    input  logic [oce_pkg::IN_W-1:0]      s_axis_tdata,
    // kind
    input  logic [oce_pkg::KIND_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // eye_x, eye_y, eye_z, azimuth, polar, distance
    output logic [((3*POS_BITS+2*ANGLE_BITS-1+oce_pkg::RAD_W+7)/8)*8-1:0] m_axis_tdata
);
    import oce_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int OUT_W = ((3 * POS_BITS + 2 * AB - 1 + RAD_W + 7) / 8) * 8;
    localparam int DN = DRAG_W + AB;
    localparam int DCNT_W = $clog2(DN + 1);
    localparam int PW = DN + 2;
    localparam logic signed [PW-1:0] POL_LO = PW'(POLAR_EPS);
    localparam logic signed [PW-1:0] POL_HI = PW'((1 << (AB - 1)) - POLAR_EPS);
    localparam logic signed [VAL_W-1:0] POS_HI = VAL_W'((longint'(1) <<< (POS_BITS - 1)) - 1);
    localparam logic signed [VAL_W-1:0] POS_LO = -POS_HI - 1;
    localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(longint'(1) <<< Q_SHIFT);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_ISSUE  = 6'b001000,
        ST_WAIT   = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_w_reg, cfg_h_reg;
    logic [AB-1:0] az_reg, az_next, pol_reg, pol_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic signed [TARGET_W-1:0] look_x_reg, look_y_reg, look_z_reg;

    logic [KIND_W-1:0] kind_reg;
    logic signed [ZOOM_W-1:0] zoom_reg;
    logic signed [TARGET_W-1:0] tx_reg, ty_reg, tz_reg;
    logic dx_neg_reg, dy_neg_reg;

    logic [DN-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic [CFG_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    logic eye_phase_reg, eye_phase_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] step_reg, step_next;
    logic signed [VAL_W-1:0] u2_reg, u2_next, p_reg, p_next, t_reg, t_next;
    logic signed [VAL_W-1:0] sin_reg [4];
    logic signed [VAL_W-1:0] sin_next;
    logic sin_we;
    logic signed [VAL_W-1:0] off_reg [3];
    logic signed [VAL_W-1:0] off_next;
    logic off_we;

    logic m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;

    logic mul_start;
    logic signed [VAL_W-1:0] mul_a, mul_b, mul_q;
    logic mul_done;

    logic accept, cfg_write;
    logic [CFG_W-1:0] wd, hd;
    logic [CFG_W:0] rx_sh, ry_sh;
    logic ge_x, ge_y;
    logic [DRAG_W-1:0] dx_abs, dy_abs;
    logic signed [DRAG_W-1:0] dx_in, dy_in;
    logic signed [DN:0] da_s, dp_s;
    logic signed [PW-1:0] pol_sum;
    logic signed [RAD_W+1:0] rad_sum;
    logic [AB-1:0] ang;
    logic [1:0] quad;
    logic signed [VAL_W-1:0] u_cur, p_clamp;
    logic signed [VAL_W-1:0] sum_x, sum_y, sum_z, eye_x, eye_y, eye_z;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    assign prdata = (reg_idx_t'(paddr[2]) == REG_HEIGHT) ? 32'(cfg_h_reg) : 32'(cfg_w_reg);

    assign dx_in = s_axis_tdata[DRAG_W-1:0];
    assign dy_in = s_axis_tdata[2*DRAG_W-1:DRAG_W];
    assign dx_abs = dx_in[DRAG_W-1] ? DRAG_W'(-dx_in) : DRAG_W'(dx_in);
    assign dy_abs = dy_in[DRAG_W-1] ? DRAG_W'(-dy_in) : DRAG_W'(dy_in);

    assign wd = (cfg_w_reg == '0) ? CFG_W'(1) : cfg_w_reg;
    assign hd = (cfg_h_reg == '0) ? CFG_W'(1) : cfg_h_reg;
    assign rx_sh = {rx_reg, nx_reg[DN-1]};
    assign ry_sh = {ry_reg, ny_reg[DN-1]};
    assign ge_x = rx_sh >= {1'b0, wd};
    assign ge_y = ry_sh >= {1'b0, hd};

    assign da_s = dx_neg_reg ? -$signed({1'b0, nx_reg}) : $signed({1'b0, nx_reg});
    assign dp_s = dy_neg_reg ? -$signed({1'b0, ny_reg}) : $signed({1'b0, ny_reg});
    assign pol_sum = $signed(PW'(pol_reg)) + PW'(dp_s);
    assign rad_sum = $signed({2'b00, rad_reg}) + (RAD_W + 2)'(zoom_reg);

    always_comb
    begin
        case (idx_reg)
            2'd0: ang = pol_reg;
            2'd1: ang = pol_reg + AB'(1 << (AB - 2));
            2'd2: ang = az_reg;
            default: ang = az_reg + AB'(1 << (AB - 2));
        endcase
    end

    assign quad = ang[AB-1:AB-2];
    assign u_cur = quad[0] ? ONE_Q - VAL_W'({ang[AB-3:0], {(32 - AB){1'b0}}})
                           : VAL_W'({ang[AB-3:0], {(32 - AB){1'b0}}});
    assign p_clamp = (mul_q > ONE_Q) ? ONE_Q : ((mul_q < -ONE_Q) ? -ONE_Q : mul_q);

    always_comb
    begin
        mul_a = p_reg;
        mul_b = u2_reg;
        if (eye_phase_reg)
        begin
            case (idx_reg)
                2'd0:
                begin
                    mul_a = VAL_W'(rad_reg);
                    mul_b = sin_reg[0];
                end
                2'd1:
                begin
                    mul_a = t_reg;
                    mul_b = sin_reg[2];
                end
                2'd2:
                begin
                    mul_a = VAL_W'(rad_reg);
                    mul_b = sin_reg[1];
                end
                default:
                begin
                    mul_a = t_reg;
                    mul_b = sin_reg[3];
                end
            endcase
        end
        else if (step_reg == 3'd0)
        begin
            mul_a = u_cur;
            mul_b = u_cur;
        end
        else if (step_reg == 3'd6)
        begin
            mul_a = p_reg;
            mul_b = u_cur;
        end
    end

    assign mul_start = (state_reg == ST_ISSUE);

    oce_qmul u_qmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .q     (mul_q),
        .done  (mul_done)
    );

    assign sum_x = VAL_W'(look_x_reg) + off_reg[0];
    assign sum_y = VAL_W'(look_y_reg) + off_reg[1];
    assign sum_z = VAL_W'(look_z_reg) + off_reg[2];
    assign eye_x = (sum_x > POS_HI) ? POS_HI : ((sum_x < POS_LO) ? POS_LO : sum_x);
    assign eye_y = (sum_y > POS_HI) ? POS_HI : ((sum_y < POS_LO) ? POS_LO : sum_y);
    assign eye_z = (sum_z > POS_HI) ? POS_HI : ((sum_z < POS_LO) ? POS_LO : sum_z);

    always_comb
    begin
        state_next = state_reg;
        nx_next = nx_reg;
        ny_next = ny_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        dcnt_next = dcnt_reg;
        az_next = az_reg;
        pol_next = pol_reg;
        rad_next = rad_reg;
        eye_phase_next = eye_phase_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        u2_next = u2_reg;
        p_next = p_reg;
        t_next = t_reg;
        sin_next = p_clamp;
        sin_we = 1'b0;
        off_next = mul_q;
        off_we = 1'b0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next = m_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    nx_next = DN'({dx_abs, {AB{1'b0}}});
                    ny_next = DN'({dy_abs, {(AB - 1){1'b0}}});
                    rx_next = '0;
                    ry_next = '0;
                    dcnt_next = DCNT_W'(DN);
                    state_next = (kind_t'(s_axis_tuser) == KIND_ROTATE) ? ST_DIV : ST_UPDATE;
                end
            end
            ST_DIV:
            begin
                rx_next = ge_x ? CFG_W'(rx_sh - {1'b0, wd}) : CFG_W'(rx_sh);
                ry_next = ge_y ? CFG_W'(ry_sh - {1'b0, hd}) : CFG_W'(ry_sh);
                nx_next = {nx_reg[DN-2:0], ge_x};
                ny_next = {ny_reg[DN-2:0], ge_y};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                case (kind_t'(kind_reg))
                    KIND_ROTATE:
                    begin
                        az_next = az_reg + da_s[AB-1:0];
                        if (pol_sum < POL_LO)
                        begin
                            pol_next = AB'(POL_LO);
                        end
                        else if (pol_sum > POL_HI)
                        begin
                            pol_next = AB'(POL_HI);
                        end
                        else
                        begin
                            pol_next = AB'(pol_sum);
                        end
                    end
                    KIND_ZOOM:
                    begin
                        if (rad_sum < (RAD_W + 2)'(RADIUS_MIN))
                        begin
                            rad_next = RAD_W'(RADIUS_MIN);
                        end
                        else if (rad_sum > (RAD_W + 2)'(RADIUS_MAX))
                        begin
                            rad_next = RAD_W'(RADIUS_MAX);
                        end
                        else
                        begin
                            rad_next = RAD_W'(rad_sum);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                eye_phase_next = 1'b0;
                idx_next = '0;
                step_next = '0;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_ISSUE;
                    if (eye_phase_reg)
                    begin
                        if (idx_reg == 2'd0)
                        begin
                            t_next = mul_q;
                        end
                        else
                        begin
                            off_we = 1'b1;
                        end
                        idx_next = idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    else if (step_reg == 3'd0)
                    begin
                        u2_next = mul_q;
                        p_next = SIN_COEF[5];
                        step_next = step_reg + 1'b1;
                    end
                    else if (step_reg == 3'd6)
                    begin
                        sin_next = quad[1] ? -p_clamp : p_clamp;
                        sin_we = 1'b1;
                        step_next = '0;
                        idx_next = idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                        begin
                            eye_phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        p_next = SIN_COEF[3'd5 - step_reg] + mul_q;
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next = OUT_W'({rad_reg, pol_reg[AB-2:0], az_reg,
                                          eye_z[POS_BITS-1:0], eye_y[POS_BITS-1:0],
                                          eye_x[POS_BITS-1:0]});
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_w_reg <= CFG_W'(WIDTH_RST);
            cfg_h_reg <= CFG_W'(HEIGHT_RST);
            az_reg <= AB'(1 << (AB - 3));
            pol_reg <= AB'(1 << (AB - 3));
            rad_reg <= RAD_W'(RADIUS_RST);
            look_x_reg <= '0;
            look_y_reg <= '0;
            look_z_reg <= '0;
            m_valid_reg <= 1'b0;
            dcnt_reg <= '0;
            eye_phase_reg <= 1'b0;
            idx_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (reg_idx_t'(paddr[2]) == REG_HEIGHT)
                begin
                    cfg_h_reg <= pwdata[CFG_W-1:0];
                end
                else
                begin
                    cfg_w_reg <= pwdata[CFG_W-1:0];
                end
            end
            az_reg <= az_next;
            pol_reg <= pol_next;
            rad_reg <= rad_next;
            if (state_reg == ST_UPDATE && kind_t'(kind_reg) == KIND_SET)
            begin
                look_x_reg <= tx_reg;
                look_y_reg <= ty_reg;
                look_z_reg <= tz_reg;
            end
            m_valid_reg <= m_valid_next;
            dcnt_reg <= dcnt_next;
            eye_phase_reg <= eye_phase_next;
            idx_reg <= idx_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            dx_neg_reg <= dx_in[DRAG_W-1];
            dy_neg_reg <= dy_in[DRAG_W-1];
            zoom_reg <= s_axis_tdata[2*DRAG_W+ZOOM_W-1:2*DRAG_W];
            tx_reg <= s_axis_tdata[2*DRAG_W+ZOOM_W+TARGET_W-1:2*DRAG_W+ZOOM_W];
            ty_reg <= s_axis_tdata[2*DRAG_W+ZOOM_W+2*TARGET_W-1:2*DRAG_W+ZOOM_W+TARGET_W];
            tz_reg <= s_axis_tdata[2*DRAG_W+ZOOM_W+3*TARGET_W-1:2*DRAG_W+ZOOM_W+2*TARGET_W];
        end
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        u2_reg <= u2_next;
        p_reg <= p_next;
        t_reg <= t_next;
        if (sin_we)
        begin
            sin_reg[idx_reg] <= sin_next;
        end
        if (off_we)
        begin
            off_reg[2'(idx_reg - 1'b1)] <= off_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule
